// ===== design/tmsh_pkg.sv =====
// Package for the table-mixed string hash unit: constant tables, rotation
// helpers, multiply-accumulate control types. No dependencies.

package tmsh_pkg;

  localparam logic [63:0] HASH_START = 64'h0000_0000_0009_d200;

  // Index offsets used by the final mix; all table indexes wrap at 128.
  localparam logic [6:0] FIN_SUB_OFS  = 7'd37;
  localparam logic [6:0] FIN_ROT_OFS  = 7'd97;
  localparam logic [6:0] FIN_ROT2_OFS = 7'd67;

  localparam logic [9:0] PRIME_TAB [128] = '{
    10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,
    10'd23,  10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,
    10'd59,  10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,
    10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131,
    10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
    10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
    10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
    10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311,
    10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359,
    10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
    10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457,
    10'd461, 10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503,
    10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569,
    10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613,
    10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
    10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719
  };

  localparam logic [19:0] MIX_TAB [128] = '{
    20'h65992, 20'hf1b28, 20'h4540e, 20'hb80ee, 20'h01149, 20'hdd8b6, 20'h432db, 20'hf1620,
    20'h82161, 20'hb6a19, 20'hdf536, 20'hbade6, 20'hf10cb, 20'h87869, 20'hf244f, 20'he030a,
    20'hbc408, 20'h3f035, 20'h7e689, 20'h4b71e, 20'hb3bc0, 20'hdabe2, 20'h3cec4, 20'h7c8e1,
    20'he1ddb, 20'hd9c64, 20'hbef96, 20'hefefb, 20'h8cdea, 20'hf2fc2, 20'h38ba7, 20'h8ea10,
    20'h51955, 20'haf48c, 20'h369fc, 20'hef19a, 20'hf35de, 20'he43f4, 20'hd6c48, 20'heea76,
    20'hf3878, 20'h55a4d, 20'hc43d1, 20'h32674, 20'h93d6f, 20'h73249, 20'hd4adc, 20'hf3cbf,
    20'ha928a, 20'he677a, 20'hd39c0, 20'hed341, 20'h97418, 20'he72bd, 20'hc8069, 20'h98f23,
    20'h5daee, 20'ha6041, 20'hd16bb, 20'h29ea7, 20'hec24a, 20'ha46cc, 20'h9c4a7, 20'hf41a3,
    20'h61a8c, 20'he92ca, 20'h678d7, 20'ha1346, 20'h2383e, 20'hea6a1, 20'h65977, 20'h9f934,
    20'hce05e, 20'ha1373, 20'h6790e, 20'heb036, 20'hcf2ca, 20'h61a55, 20'h6984d, 20'hca76c,
    20'h5fa95, 20'hf40de, 20'hc93fa, 20'hd16da, 20'ha606d, 20'hf3fcc, 20'hecafa, 20'h18cb3,
    20'ha79ac, 20'h5bab9, 20'h6f53b, 20'h16a4a, 20'hf3cbc, 20'h958ac, 20'hd4afa, 20'he5bd8,
    20'hf3abf, 20'hd5bd2, 20'h12562, 20'hc2efb, 20'he43df, 20'h905d9, 20'hc1a0b, 20'he3774,
    20'haf4b6, 20'h78d4c, 20'hd8cbc, 20'hb0caa, 20'h7ab44, 20'h8cdb8, 20'hbef71, 20'he1dc4,
    20'h4d7bb, 20'hf2c39, 20'hdabfd, 20'hf2867, 20'h7e6bd, 20'hf0b32, 20'hdbb35, 20'hb5332,
    20'h495f7, 20'hbadbf, 20'h033a0, 20'h474f1, 20'hf1629, 20'hde701, 20'h83ec1, 20'hde733
  };

  // Shift applied to a partial product before it enters the accumulator.
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_20 = 2'd1,
    SH_32 = 2'd2,
    SH_52 = 2'd3
  } pp_shift_e;

  typedef struct packed {
    logic      en;    // update the accumulator this cycle
    logic      clr;   // start from zero instead of the current sum
    pp_shift_e shift;
  } mac_ctrl_t;

  function automatic logic [63:0] rot_left(input logic [63:0] v, input logic [5:0] s);
    logic [127:0] t;
    t = {v, v} << s;
    return t[127:64];
  endfunction

  function automatic logic [63:0] rot_right(input logic [63:0] v, input logic [5:0] s);
    logic [127:0] t;
    t = {v, v} >> s;
    return t[63:0];
  endfunction

endpackage

// ===== design/tmsh_mac.sv =====
// Shared 32x20 multiply-accumulate unit with a 64-bit accumulator.
// Depends on tmsh_pkg for the control struct and shift codes.

module tmsh_mac import tmsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mac_ctrl_t   ctrl_i,
  input  logic [31:0] x_i,
  input  logic [19:0] y_i,
  output logic [63:0] acc_o
);

  logic [63:0] acc_q, acc_d;
  logic [51:0] prod;
  logic [63:0] prod_ext;
  logic [63:0] pp;
  logic [63:0] base;

  assign prod     = {20'd0, x_i} * {32'd0, y_i};
  assign prod_ext = {12'd0, prod};

  always_comb begin
    case (ctrl_i.shift)
      SH_0:    pp = prod_ext;
      SH_20:   pp = prod_ext << 20;
      SH_32:   pp = prod_ext << 32;
      SH_52:   pp = prod_ext << 52;
      default: pp = prod_ext;
    endcase
    base  = ctrl_i.clr ? 64'd0 : acc_q;
    // The sum wraps at 64 bits, which is exactly the modulo 2^64 product.
    acc_d = ctrl_i.en ? base + pp : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 64'd0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== design/table_mixed_string_hash_unit.sv =====
// Top level of the table-mixed string hash: sequencer, hash state, output
// register. Depends on tmsh_pkg and tmsh_mac.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | char_code_i, has_char_i, last_char_i
//  out     | output    | out_valid_o/out_ready_i| hash_value_o
//
// A character goes through its accept cycle, MUL_A, MUL_B, HB0-HB3, ROT1, ROT2;
// ending a key adds the final mix FIN1-FIN4, an empty-key item goes straight
// to FIN1, an idle item ends at acceptance. On the shared 32x20 multiplier the 64x37
// product of hash and character word takes four passes, the final product two.
// in_ready_o is high only while the sequencer is idle.
// Reset loads the start value into the running hash and empties the output.
// A finished hash waits in the output register; the next key may be absorbed
// meanwhile, and only a second finished hash waits for the first to be taken.

module table_mixed_string_hash_unit import tmsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [6:0]  char_code_i,
  input  logic        has_char_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_HB0,
    ST_HB1,
    ST_HB2,
    ST_HB3,
    ST_ROT1,
    ST_ROT2,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_FIN4
  } state_e;

  state_e      state_q;
  logic [6:0]  char_q;
  logic        last_q;
  logic [63:0] h_q;
  logic [6:0]  a_q;
  logic [36:0] b_q;
  logic        out_valid_q;
  logic [63:0] out_hash_q;

  mac_ctrl_t   mac_ctrl;
  logic [31:0] mac_x;
  logic [19:0] mac_y;
  logic [63:0] acc;

  logic        in_fire;
  logic        fin_go;
  logic [6:0]  a_acc;
  logic [6:0]  h_lo;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign fin_go       = (state_q == ST_FIN4) && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;
  assign a_acc        = acc[6:0];
  assign h_lo         = h_q[6:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_ctrl = '{en: 1'b0, clr: 1'b0, shift: SH_0};
    mac_x    = 32'd0;
    mac_y    = 20'd0;
    case (state_q)
      ST_MUL_A: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b1, shift: SH_0};
        mac_x    = {25'd0, char_q};
        mac_y    = {10'd0, PRIME_TAB[char_q]};
      end
      ST_MUL_B: begin
        // The accumulator holds a, which fits in 17 bits.
        mac_ctrl = '{en: 1'b1, clr: 1'b1, shift: SH_0};
        mac_x    = {15'd0, acc[16:0]};
        mac_y    = MIX_TAB[a_acc + 7'd1] ^ MIX_TAB[a_acc - 7'd1];
      end
      ST_HB0: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b1, shift: SH_0};
        mac_x    = h_q[31:0];
        mac_y    = acc[19:0];
      end
      ST_HB1: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b0, shift: SH_32};
        mac_x    = h_q[63:32];
        mac_y    = b_q[19:0];
      end
      ST_HB2: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b0, shift: SH_20};
        mac_x    = h_q[31:0];
        mac_y    = {3'd0, b_q[36:20]};
      end
      ST_HB3: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b0, shift: SH_52};
        mac_x    = h_q[63:32];
        mac_y    = {3'd0, b_q[36:20]};
      end
      ST_FIN2: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b1, shift: SH_0};
        mac_x    = h_q[31:0];
        mac_y    = MIX_TAB[h_lo];
      end
      ST_FIN3: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b0, shift: SH_32};
        mac_x    = h_q[63:32];
        mac_y    = MIX_TAB[h_lo];
      end
      default: begin
        mac_ctrl = '{en: 1'b0, clr: 1'b0, shift: SH_0};
      end
    endcase
  end

  tmsh_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .x_i    (mac_x),
    .y_i    (mac_y),
    .acc_o  (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      h_q         <= HASH_START;
      out_valid_q <= 1'b0;
      out_hash_q  <= 64'd0;
      last_q      <= 1'b0;
      char_q      <= 7'd0;
      a_q         <= 7'd0;
      b_q         <= 37'd0;
    end else begin
      if (out_valid_q && out_ready_i && !fin_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            char_q <= char_code_i;
            last_q <= last_char_i;
            if (has_char_i) begin
              state_q <= ST_MUL_A;
            end else if (last_char_i) begin
              state_q <= ST_FIN1;
            end
          end
        end
        ST_MUL_A: state_q <= ST_MUL_B;
        ST_MUL_B: begin
          a_q     <= a_acc;
          state_q <= ST_HB0;
        end
        ST_HB0: begin
          b_q     <= acc[36:0];
          state_q <= ST_HB1;
        end
        ST_HB1: state_q <= ST_HB2;
        ST_HB2: state_q <= ST_HB3;
        ST_HB3: state_q <= ST_ROT1;
        ST_ROT1: begin
          h_q     <= rot_right(acc, PRIME_TAB[a_q + 7'd1][5:0]) ^ {44'd0, MIX_TAB[a_q]};
          state_q <= ST_ROT2;
        end
        ST_ROT2: begin
          h_q     <= rot_left(h_q ^ {44'd0, MIX_TAB[b_q[6:0]]},
                              PRIME_TAB[a_q - 7'd1][5:0]);
          state_q <= last_q ? ST_FIN1 : ST_IDLE;
        end
        ST_FIN1: begin
          h_q     <= rot_left(h_q ^ {44'd0, MIX_TAB[h_lo - FIN_SUB_OFS]},
                              PRIME_TAB[h_lo + FIN_ROT_OFS][5:0]);
          state_q <= ST_FIN2;
        end
        ST_FIN2: state_q <= ST_FIN3;
        ST_FIN3: state_q <= ST_FIN4;
        ST_FIN4: begin
          // The rotation amount comes from the hash before the final product.
          if (fin_go) begin
            out_hash_q  <= rot_right(acc, PRIME_TAB[h_lo + FIN_ROT2_OFS][5:0]);
            out_valid_q <= 1'b1;
            h_q         <= HASH_START;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_char_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && has_char_i) |=> (state_q == ST_MUL_A))
    else $error("character transaction did not start the multiply sequence");

  a_idle_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !has_char_i && !last_char_i) |=> (state_q == ST_IDLE) && $stable(h_q))
    else $error("idle transaction changed the running hash");

  a_emit_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_o && (h_q == HASH_START) && (state_q == ST_IDLE))
    else $error("hash emission did not reload the start value");

  a_rose_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_FIN4))
    else $error("output became valid outside the final step");

endmodule
